// ===== design/slae_pkg.sv =====
// Shared types and constants for the status LED animation engine.
// No dependencies; every other design file imports this package.
package slae_pkg;

   localparam int IDX_W     = 6;
   localparam int CHAN_W    = 8;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 2;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LED_COUNT  = 2'd1;

   localparam logic [CFG_W-1:0] BRIGHT_MAX      = 7'd100;
   localparam logic [CFG_W-1:0] BRIGHT_RESET    = 7'd50;
   localparam logic [CFG_W-1:0] LED_COUNT_RESET = 7'd64;

   localparam logic [CFG_W-1:0] BREATH_STEP = 7'd5;
   localparam logic [CFG_W-1:0] BREATH_TOP  = 7'd100;

   localparam logic [CHAN_W-1:0] RUN_LVL_HEAD = 8'd255;
   localparam logic [CHAN_W-1:0] RUN_LVL_MID  = 8'd127;
   localparam logic [CHAN_W-1:0] RUN_LVL_TAIL = 8'd63;

   // x/100 == (x*5243)>>19 for every x up to 255*100
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   localparam int QUEUE_DEPTH = 2;

   // one frame's worth of work for the pixel generator
   typedef struct packed {
      logic              run;
      logic              purple;
      logic [IDX_W-1:0]  pos0;
      logic [IDX_W-1:0]  pos1;
      logic [IDX_W-1:0]  pos2;
      logic [CHAN_W-1:0] lvl0;
      logic [CHAN_W-1:0] lvl1;
      logic [CHAN_W-1:0] lvl2;
      logic [IDX_W-1:0]  last_idx;
   } frame_desc_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ===== design/slae_front.sv =====
// Frame front end: accepts a tick, steps the animation state and
// precomputes the scaled levels for the frame. Depends on slae_pkg.
module slae_front #(
   parameter int MAX_LEDS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          usb_link,
   input  logic                          ble_link,
   input  logic [slae_pkg::CFG_W-1:0]    bright,
   input  logic [slae_pkg::CFG_W-1:0]    led_count,
   output slae_pkg::frame_desc_type      desc,
   output logic                          desc_push,
   input  slae_pkg::queue_status_type    q_status
);
   import slae_pkg::*;

   typedef enum logic [1:0] {F_IDLE, F_REDUCE, F_SCALE, F_PUSH} front_state_type;

   front_state_type   state_ff, state_in;
   logic              run_ff, run_in;
   logic              purple_ff, purple_in;
   logic [CFG_W-1:0]  level_ff, level_in;
   logic              rising_ff, rising_in;
   logic [IDX_W-1:0]  runpos_ff, runpos_in;
   logic [IDX_W-1:0]  p_ff, p_in;
   logic [IDX_W-1:0]  pos1_ff, pos1_in;
   logic [IDX_W-1:0]  pos2_ff, pos2_in;
   logic [IDX_W-1:0]  last_ff, last_in;
   logic [1:0]        k_ff, k_in;
   logic [14:0]       prod_ff, prod_in;
   logic [CHAN_W-1:0] v_ff [3];
   logic [CHAN_W-1:0] v_in [3];
   logic [CHAN_W-1:0] s_ff [3];
   logic [CHAN_W-1:0] s_in [3];

   logic [CFG_W-1:0]  n;
   logic [CFG_W:0]    breath_sum;
   logic [CFG_W-1:0]  breath_next;
   logic [CFG_W-1:0]  sum1, sum2, red1, red2;
   logic [27:0]       quot_full;

   // clamp the string length to the supported range
   always_comb begin
      if (led_count == '0) begin
         n = 7'd1;
      end else if (led_count > 7'(MAX_LEDS)) begin
         n = 7'(MAX_LEDS);
      end else begin
         n = led_count;
      end
   end

   // wrap the two positions behind the head of the running light
   always_comb begin
      sum1 = {1'b0, p_ff} + 7'd1;
      red1 = (sum1 >= n) ? (sum1 - n) : sum1;
      sum2 = {1'b0, red1[IDX_W-1:0]} + 7'd1;
      red2 = (sum2 >= n) ? (sum2 - n) : sum2;
   end

   assign breath_sum = {1'b0, level_ff} + {1'b0, BREATH_STEP};
   assign quot_full  = prod_ff * RECIP_100;

   // next-state logic of the front sequencer
   always_comb begin
      state_in    = state_ff;
      run_in      = run_ff;
      purple_in   = purple_ff;
      level_in    = level_ff;
      rising_in   = rising_ff;
      runpos_in   = runpos_ff;
      p_in        = p_ff;
      pos1_in     = pos1_ff;
      pos2_in     = pos2_ff;
      last_in     = last_ff;
      k_in        = k_ff;
      prod_in     = prod_ff;
      v_in        = v_ff;
      s_in        = s_ff;
      breath_next = '0;
      case (state_ff)
         F_IDLE: begin
            if (req_push) begin
               run_in    = usb_link | ble_link;
               purple_in = ble_link;
               last_in   = 6'(n - 7'd1);
               k_in      = '0;
               if (usb_link | ble_link) begin
                  p_in     = runpos_ff;
                  v_in[0]  = RUN_LVL_HEAD;
                  v_in[1]  = RUN_LVL_MID;
                  v_in[2]  = RUN_LVL_TAIL;
                  state_in = F_REDUCE;
               end else begin
                  // step the breathing level and turn at the ends
                  if (rising_ff) begin
                     breath_next = breath_sum[CFG_W-1:0];
                     if (breath_sum >= {1'b0, BREATH_TOP}) begin
                        rising_in = 1'b0;
                     end
                  end else begin
                     breath_next = (level_ff <= BREATH_STEP) ? '0 : (level_ff - BREATH_STEP);
                     if (breath_next == '0) begin
                        rising_in = 1'b1;
                     end
                  end
                  level_in = breath_next;
                  v_in[0]  = {1'b0, breath_next};
                  v_in[1]  = {1'b0, breath_next};
                  v_in[2]  = {1'b0, breath_next};
                  state_in = F_SCALE;
               end
            end
         end
         F_REDUCE: begin
            // bring a stale position below the count, one subtract a cycle
            if ({1'b0, p_ff} >= n) begin
               p_in = 6'({1'b0, p_ff} - n);
            end else begin
               pos1_in   = red1[IDX_W-1:0];
               pos2_in   = red2[IDX_W-1:0];
               runpos_in = red1[IDX_W-1:0];
               state_in  = F_SCALE;
            end
         end
         F_SCALE: begin
            // multiply by brightness, then divide by 100 through the reciprocal
            if (k_ff != 2'd3) begin
               prod_in = v_ff[k_ff] * bright;
            end
            if (k_ff != 2'd0) begin
               s_in[k_ff - 2'd1] = quot_full[RECIP_SHIFT +: CHAN_W];
            end
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_status.full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // hold state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         level_ff  <= '0;
         rising_ff <= 1'b1;
         runpos_ff <= '0;
      end else begin
         state_ff  <= state_in;
         level_ff  <= level_in;
         rising_ff <= rising_in;
         runpos_ff <= runpos_in;
      end
      run_ff    <= run_in;
      purple_ff <= purple_in;
      p_ff      <= p_in;
      pos1_ff   <= pos1_in;
      pos2_ff   <= pos2_in;
      last_ff   <= last_in;
      k_ff      <= k_in;
      prod_ff   <= prod_in;
      v_ff      <= v_in;
      s_ff      <= s_in;
   end

   assign req_full  = (state_ff != F_IDLE);
   assign desc_push = (state_ff == F_PUSH) && !q_status.full;

   assign desc.run      = run_ff;
   assign desc.purple   = purple_ff;
   assign desc.pos0     = p_ff;
   assign desc.pos1     = pos1_ff;
   assign desc.pos2     = pos2_ff;
   assign desc.lvl0     = s_ff[0];
   assign desc.lvl1     = s_ff[1];
   assign desc.lvl2     = s_ff[2];
   assign desc.last_idx = last_ff;

endmodule

// ===== design/slae_queue.sv =====
// Short frame queue between the front end and the pixel generator.
// Depends on slae_pkg for the frame type and the queue depth.
module slae_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  slae_pkg::frame_desc_type   wdata,
   input  logic                       pop,
   output slae_pkg::frame_desc_type   rdata,
   output slae_pkg::queue_status_type status
);
   import slae_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_desc_type   slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : (ptr + 1'b1);
   endfunction

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata        = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));

endmodule

// ===== design/slae_back.sv =====
// Pixel generator: walks the LEDs of the head frame into the output
// register, one per cycle if rsp_pop keeps up. Depends on slae_pkg.
module slae_back (
   input  logic                            clock,
   input  logic                            reset,
   input  slae_pkg::frame_desc_type        head,
   input  logic                            q_empty,
   output logic                            desc_pop,
   input  logic                            rsp_pop,
   output logic                            rsp_empty,
   output logic [slae_pkg::IDX_W-1:0]      rsp_led_index,
   output logic [slae_pkg::CHAN_W-1:0]     rsp_red,
   output logic [slae_pkg::CHAN_W-1:0]     rsp_green,
   output logic [slae_pkg::CHAN_W-1:0]     rsp_blue,
   output logic                            rsp_frame_last
);
   import slae_pkg::*;

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]  out_idx_ff;
   logic [CHAN_W-1:0] out_red_ff, out_blue_ff;
   logic              out_last_ff;
   logic              load, is_last;
   logic [CHAN_W-1:0] lvl, red_val, blue_val;

   assign load    = !q_empty && (!out_valid_ff || rsp_pop);
   assign is_last = (idx_ff == head.last_idx);

   // pick this LED's level; later positions win on short strings
   always_comb begin
      if (!head.run) begin
         lvl = '0;
         red_val  = '0;
         blue_val = head.lvl0;
      end else begin
         if (idx_ff == head.pos2) begin
            lvl = head.lvl2;
         end else if (idx_ff == head.pos1) begin
            lvl = head.lvl1;
         end else if (idx_ff == head.pos0) begin
            lvl = head.lvl0;
         end else begin
            lvl = '0;
         end
         red_val  = head.purple ? lvl : '0;
         blue_val = lvl;
      end
   end

   // advance the LED index and the output register
   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         idx_in       = is_last ? '0 : (idx_ff + 1'b1);
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      if (load) begin
         out_idx_ff  <= idx_ff;
         out_red_ff  <= red_val;
         out_blue_ff <= blue_val;
         out_last_ff <= is_last;
      end
   end

   assign desc_pop       = load && is_last;
   assign rsp_empty      = !out_valid_ff;
   assign rsp_led_index  = out_idx_ff;
   assign rsp_red        = out_red_ff;
   assign rsp_green      = '0;
   assign rsp_blue       = out_blue_ff;
   assign rsp_frame_last = out_last_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !out_valid_ff)
      else $error("output register valid after reset");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (load && !is_last) |=> (idx_ff == $past(idx_ff) + 1'b1))
      else $error("LED index skipped within a frame");

   a_index_wrap: assert property (@(posedge clock) disable iff (reset)
      (load && is_last) |=> (idx_ff == '0))
      else $error("LED index not restarted after last LED");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> (out_valid_ff && $stable(out_idx_ff)))
      else $error("waiting result dropped or changed");

endmodule

// ===== design/status_led_animation_engine.sv =====
// Top level of the status LED animation engine: configuration registers,
// front end, frame queue and pixel generator. Depends on slae_pkg.
//
//   channel   direction  handshake            payload
//   req_      in         req_push / req_full  usb_link, ble_link
//   rsp_      out        rsp_empty / rsp_pop  led_index, red, green, blue, frame_last
//   csr_      in         csr_write            csr_index, csr_wdata
//
// Front end: an accept state, on running-light frames a position-reduce
// state (it subtracts only when the LED count was lowered below the run
// position), a scaling state through one multiplier pair and a push into
// the frame queue; a new tick is taken only once the frame is pushed.
// Pixel generator: one result per cycle while the frame queue is not
// empty and rsp_pop takes each result.
// Reset is synchronous and clears control state; no clearing pass.
// A stalled rsp_pop holds the generator; the front end stalls only when
// the frame queue is full.
module status_led_animation_engine #(
   parameter int MAX_LEDS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic                               req_usb_link,
   input  logic                               req_ble_link,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [slae_pkg::IDX_W-1:0]         rsp_led_index,
   output logic [slae_pkg::CHAN_W-1:0]        rsp_red,
   output logic [slae_pkg::CHAN_W-1:0]        rsp_green,
   output logic [slae_pkg::CHAN_W-1:0]        rsp_blue,
   output logic                               rsp_frame_last,
   input  logic                               csr_write,
   input  logic [slae_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [slae_pkg::CFG_W-1:0]         csr_wdata
);
   import slae_pkg::*;

   logic [CFG_W-1:0] bright_ff, bright_in;
   logic [CFG_W-1:0] count_ff, count_in;
   logic [CFG_W-1:0] bright_clamped;

   frame_desc_type   front_desc, head_desc;
   logic             desc_push, desc_pop;
   queue_status_type q_status;

   // take configuration writes; unknown indexes drop
   always_comb begin
      bright_in = bright_ff;
      count_in  = count_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_BRIGHTNESS: bright_in = csr_wdata;
            CSR_LED_COUNT:  count_in  = csr_wdata;
            default: begin
               bright_in = bright_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff <= BRIGHT_RESET;
         count_ff  <= LED_COUNT_RESET;
      end else begin
         bright_ff <= bright_in;
         count_ff  <= count_in;
      end
   end

   // cap brightness so scaled channels stay within 8 bits
   assign bright_clamped = (bright_ff > BRIGHT_MAX) ? BRIGHT_MAX : bright_ff;

   slae_front #(
      .MAX_LEDS (MAX_LEDS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .usb_link      (req_usb_link),
      .ble_link      (req_ble_link),
      .bright        (bright_clamped),
      .led_count     (count_ff),
      .desc          (front_desc),
      .desc_push     (desc_push),
      .q_status      (q_status)
   );

   slae_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (desc_push),
      .wdata  (front_desc),
      .pop    (desc_pop),
      .rdata  (head_desc),
      .status (q_status)
   );

   slae_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head_desc),
      .q_empty        (q_status.empty),
      .desc_pop       (desc_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_led_index  (rsp_led_index),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
